[design/gst_pkg.sv]
// shared types and constants for the group set table
`default_nettype none
package gst_pkg;

    // table geometry
    localparam int SLOTS   = 16;
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int GID_W   = 16;
    localparam int OP_W    = 2;
    localparam int ENTRY_W = 5;

    // empty slot marker
    localparam logic [GID_W-1:0] EMPTY_ID = {GID_W{1'b1}};

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // request payload
    typedef struct packed {
        logic [OP_W-1:0]  req_type;
        logic [GID_W-1:0] group_id;
    } t_req;

    // result payload
    typedef struct packed {
        logic               is_member;
        logic               table_full;
        logic [ENTRY_W-1:0] entry_count;
    } t_rsp;

    // sequencer to table storage
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [GID_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
        logic [GID_W-1:0] key;
    } t_store_cmd;

    // table storage back to sequencer
    typedef struct packed {
        logic [GID_W-1:0] rdata;
        logic             hit;
    } t_store_rsp;

endpackage
`default_nettype wire

[design/gst_store.sv]
// slot storage with one read port, one write port and the shared id comparator
`default_nettype none
module gst_store (
    input  wire                  i_clk,
    input  gst_pkg::t_store_cmd  i_cmd,
    output gst_pkg::t_store_rsp  o_rsp
);

    // slot array, read data is only used within the occupied prefix
    logic [gst_pkg::GID_W-1:0] r_mem [gst_pkg::SLOTS];
    logic [gst_pkg::GID_W-1:0] r_rdata;

    // single write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        r_rdata <= r_mem[i_cmd.raddr];
    end

    // read data and compare against the key
    always_comb begin
        o_rsp.rdata = r_rdata;
        o_rsp.hit   = (r_rdata == i_cmd.key);
    end

endmodule
`default_nettype wire

[design/group_set_table.sv]
// group set table top level: request sequencer, count and effective gid register
`default_nettype none
// A request (insert, remove or membership query of a 16-bit group id) is taken
// when start is high and busy is low; busy then stays high until the result.
// The result appears on o_rsp with o_done high for exactly one cycle and must
// be captured then, there is no way to hold it off. One slot of the table is
// visited per cycle through a single compare port: a request scans the
// occupied slots in order until a match, and a remove that hits then shifts
// every entry behind the match down by one slot. The effective gid may be
// written at any idle time and takes effect on the next query.
// No clearing pass is needed after reset.
module group_set_table (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  gst_pkg::t_req       i_req,
    input  wire                 i_cfg_we,
    input  wire  [15:0]         i_cfg_data,
    output logic                o_done,
    output gst_pkg::t_rsp       o_rsp
);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;

    logic [1:0]                r_state, n_state;
    logic [gst_pkg::CNT_W-1:0] r_idx,   n_idx;
    logic [gst_pkg::CNT_W-1:0] r_count, n_count;
    logic [gst_pkg::OP_W-1:0]  r_op,    n_op;
    logic [gst_pkg::GID_W-1:0] r_id,    n_id;
    logic [gst_pkg::GID_W-1:0] r_egid;
    logic                      r_done,  n_done;
    gst_pkg::t_rsp             r_rsp,   n_rsp;

    gst_pkg::t_store_cmd       st_cmd;
    gst_pkg::t_store_rsp       st_rsp;
    logic [gst_pkg::CNT_W-1:0] idx_inc;
    logic                      fin;
    logic                      set_member;
    logic                      set_full;

    gst_store u_store (
        .i_clk (i_clk),
        .i_cmd (st_cmd),
        .o_rsp (st_rsp)
    );

    assign idx_inc = r_idx + gst_pkg::CNT_W'(1);
    assign busy    = (r_state != ST_IDLE);
    assign o_done  = r_done;
    assign o_rsp   = r_rsp;

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_count    = r_count;
        n_op       = r_op;
        n_id       = r_id;
        n_done     = 1'b0;
        n_rsp      = r_rsp;
        fin        = 1'b0;
        set_member = 1'b0;
        set_full   = 1'b0;
        st_cmd.we    = 1'b0;
        st_cmd.waddr = r_count[gst_pkg::IDX_W-1:0];
        st_cmd.wdata = r_id;
        st_cmd.raddr = r_idx[gst_pkg::IDX_W-1:0];
        st_cmd.key   = r_id;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_SCAN;
                    n_idx   = '0;
                    n_op    = i_req.req_type;
                    n_id    = i_req.group_id;
                end
            end
            ST_SCAN: begin
                priority if (r_op == gst_pkg::OP_QUERY && r_id == r_egid) begin
                    set_member = 1'b1;
                    fin        = 1'b1;
                end else if (r_id == gst_pkg::EMPTY_ID || r_op == gst_pkg::OP_NONE) begin
                    fin = 1'b1;
                end else if (r_idx >= r_count) begin
                    // id absent: append on insert if there is room
                    if (r_op == gst_pkg::OP_INSERT) begin
                        if (r_count < gst_pkg::CNT_W'(gst_pkg::SLOTS)) begin
                            st_cmd.we = 1'b1;
                            n_count   = r_count + gst_pkg::CNT_W'(1);
                        end else begin
                            set_full = 1'b1;
                        end
                    end
                    fin = 1'b1;
                end else if (st_rsp.hit) begin
                    if (r_op == gst_pkg::OP_REMOVE) begin
                        n_state = ST_SHIFT;
                    end else begin
                        set_member = (r_op == gst_pkg::OP_QUERY);
                        fin        = 1'b1;
                    end
                end else begin
                    n_idx = idx_inc;
                end
            end
            ST_SHIFT: begin
                // move the next entry down over the removed one
                if (idx_inc < r_count) begin
                    st_cmd.we    = 1'b1;
                    st_cmd.waddr = r_idx[gst_pkg::IDX_W-1:0];
                    st_cmd.wdata = st_rsp.rdata;
                    n_idx        = idx_inc;
                end else begin
                    n_count = r_count - gst_pkg::CNT_W'(1);
                    fin     = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // build the result
        if (fin) begin
            n_state           = ST_IDLE;
            n_done            = 1'b1;
            n_rsp.is_member   = set_member;
            n_rsp.table_full  = set_full;
            n_rsp.entry_count = gst_pkg::ENTRY_W'(n_count);
        end
        // set the read address from the next index: the slot to scan, or the entry behind it when shifting
        if (n_state == ST_SHIFT) begin
            st_cmd.raddr = n_idx[gst_pkg::IDX_W-1:0] + gst_pkg::IDX_W'(1);
        end else begin
            st_cmd.raddr = n_idx[gst_pkg::IDX_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_egid  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_egid <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_op  <= n_op;
        r_id  <= n_id;
        r_rsp <= n_rsp;
    end

`ifndef SYNTHESIS
    // a result only follows a request in flight
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) != ST_IDLE)
        else $error("result without a request in flight");

    // count stays within the table
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= gst_pkg::CNT_W'(gst_pkg::SLOTS))
        else $error("entry count beyond table size");

    // full is only reported with every slot occupied
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.table_full) |-> r_count == gst_pkg::CNT_W'(gst_pkg::SLOTS))
        else $error("full reported with free slots");

    // member and full never reported together
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_rsp.is_member && o_rsp.table_full))
        else $error("member and full both set");

    // an accepted request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");
`endif

endmodule
`default_nettype wire
